/* design/euler_angles_to_rotation_axes_assert.svh */
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_axes_assert.svh
// assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef EULER_ANGLES_TO_ROTATION_AXES_ASSERT_SVH
`define EULER_ANGLES_TO_ROTATION_AXES_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define EARA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define EARA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/eara_pkg.sv */
// ----------------------------------------------------------------------------
// eara_pkg
// shared types, constants and fixed point helpers for the rotation axes block
// ----------------------------------------------------------------------------
package eara_pkg;

  localparam int ANGLE_FRACTION_BITS  = 6;
  localparam int OUTPUT_FRACTION_BITS = 14;
  localparam int ANGLE_W              = 16;
  localparam int OUT_W                = 16;
  localparam int QBITS                = 30;
  localparam int TURN                 = 360 << ANGLE_FRACTION_BITS;
  localparam int QUARTER              = 90 << ANGLE_FRACTION_BITS;
  localparam logic [63:0] DEG2RAD_Q40 = 64'd19190098069;
  localparam int SERIES_TERMS         = 7;
  localparam int RECIP_SHIFT          = 34;
  // sine/cosine unit depth and whole block depth
  localparam int SC_LAT               = 4 + 3 * SERIES_TERMS + 1;
  localparam int LAT                  = SC_LAT + 4;

  localparam logic [7:0] SIN_DIV [SERIES_TERMS] = '{
    8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};
  localparam logic [7:0] COS_DIV [SERIES_TERMS] = '{
    8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};

  // floor(2^34 / d) for each series divisor
  localparam logic [33:0] SIN_RECIP [SERIES_TERMS] = '{
    34'((64'd1 << RECIP_SHIFT) / 64'd6),
    34'((64'd1 << RECIP_SHIFT) / 64'd20),
    34'((64'd1 << RECIP_SHIFT) / 64'd42),
    34'((64'd1 << RECIP_SHIFT) / 64'd72),
    34'((64'd1 << RECIP_SHIFT) / 64'd110),
    34'((64'd1 << RECIP_SHIFT) / 64'd156),
    34'((64'd1 << RECIP_SHIFT) / 64'd210)};
  localparam logic [33:0] COS_RECIP [SERIES_TERMS] = '{
    34'((64'd1 << RECIP_SHIFT) / 64'd2),
    34'((64'd1 << RECIP_SHIFT) / 64'd12),
    34'((64'd1 << RECIP_SHIFT) / 64'd30),
    34'((64'd1 << RECIP_SHIFT) / 64'd56),
    34'((64'd1 << RECIP_SHIFT) / 64'd90),
    34'((64'd1 << RECIP_SHIFT) / 64'd132),
    34'((64'd1 << RECIP_SHIFT) / 64'd182)};

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic signed [ANGLE_W-1:0] roll_angle;
  } angles_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] left_x;
    logic signed [OUT_W-1:0] left_y;
    logic signed [OUT_W-1:0] left_z;
    logic signed [OUT_W-1:0] up_x;
    logic signed [OUT_W-1:0] up_y;
    logic signed [OUT_W-1:0] up_z;
    logic signed [OUT_W-1:0] forward_x;
    logic signed [OUT_W-1:0] forward_y;
    logic signed [OUT_W-1:0] forward_z;
  } axes_t;

  // q30 product, rounded with ties away from zero
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic [30:0] ma;
    logic [30:0] mb;
    logic [61:0] p;
    logic [31:0] r;
    ma = a[31] ? 31'(-a) : 31'(a);
    mb = b[31] ? 31'(-b) : 31'(b);
    p  = 62'(ma) * 62'(mb) + (62'(1) << (QBITS - 1));
    r  = 32'(p >> QBITS);
    return (a[31] ^ b[31]) ? -$signed(r) : $signed(r);
  endfunction

  // q30 sum to output format, ties away from zero, saturated at plus or minus one
  function automatic logic [OUT_W-1:0] to_out(input logic signed [32:0] v);
    logic [32:0] m;
    logic [32:0] u;
    logic [32:0] r;
    m = v[32] ? 33'(-v) : 33'(v);
    u = (m + ((33'(1) << (QBITS - OUTPUT_FRACTION_BITS)) >> 1))
        >> (QBITS - OUTPUT_FRACTION_BITS);
    if (u > (33'(1) << OUTPUT_FRACTION_BITS)) begin
      u = 33'(1) << OUTPUT_FRACTION_BITS;
    end
    r = v[32] ? -u : u;
    return r[OUT_W-1:0];
  endfunction

endpackage

/* design/eara_in_if.sv */
// ----------------------------------------------------------------------------
// eara_in_if
// valid/ready channel carrying one angle triple per transaction
// ----------------------------------------------------------------------------
interface eara_in_if;
  logic             valid;
  logic             ready;
  eara_pkg::angles_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/eara_out_if.sv */
// ----------------------------------------------------------------------------
// eara_out_if
// valid/ready channel carrying the nine axis components per transaction
// ----------------------------------------------------------------------------
interface eara_out_if;
  logic           valid;
  logic           ready;
  eara_pkg::axes_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/euler_angles_to_rotation_axes.sv */
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_axes
// pitch, yaw and roll in degrees to the left, up and forward rotation axes
// ----------------------------------------------------------------------------
// Takes one angle triple (degrees, signed, 6 fraction bits, any 16-bit value
// wraps modulo a full turn) per transaction and returns one transaction with
// the nine axis components in signed Q1.14, saturated at plus or minus 16384.
// The block is a fixed 30-stage pipeline and takes a new transaction every
// cycle while the output is not stalled: 26 stages go to the sine/cosine
// units (angle wrap, quadrant split, degree to radian scaling, squaring,
// seven Taylor terms at three stages each and the quadrant fold), and 4
// stages to the products, sums and output rounding. The whole pipeline
// advances whenever the output register is empty or being taken, so a
// stalled output holds the pipe without losing or repeating anything. No
// state is kept between transactions.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_axes (
  input logic        clk,
  input logic        rst,
  eara_in_if.sink    angles,
  eara_out_if.source axes
);
  import eara_pkg::*;

  logic               en;
  logic [LAT-1:0]     vld;
  logic signed [31:0] sx, cx, sy, cy, sz, cz;

  // first product stage
  logic signed [31:0] p_cycz, p_sxsy, p_cxsy, p_cxsz, p_sxsz;
  logic signed [31:0] p_cysz, p_cxcz, p_sxcz, p_sxcy, p_cxcy;
  logic signed [31:0] p_sy, p_sz, p_cz;
  // second product stage
  logic signed [31:0] q_bcz, q_ccz, q_bsz, q_csz;
  logic signed [31:0] q_cycz, q_cxsz, q_sxsz, q_cysz, q_cxcz, q_sxcz;
  logic signed [31:0] q_sxcy, q_cxcy, q_sy;
  // sums
  logic signed [32:0] s_lx, s_ly, s_lz, s_ux, s_uy, s_uz, s_fx, s_fy, s_fz;
  axes_t              out_r;

  // pipe moves when the output slot is free or its transaction completes
  assign en           = !vld[LAT-1] || axes.ready;
  assign angles.ready = en;
  assign axes.valid   = vld[LAT-1];
  assign axes.data    = out_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], angles.valid};
    end
  end

  eara_sincos u_sc_pitch (
    .clk   (clk),
    .en    (en),
    .angle (angles.data.pitch_angle),
    .sin_q (sx),
    .cos_q (cx)
  );

  eara_sincos u_sc_yaw (
    .clk   (clk),
    .en    (en),
    .angle (angles.data.yaw_angle),
    .sin_q (sy),
    .cos_q (cy)
  );

  eara_sincos u_sc_roll (
    .clk   (clk),
    .en    (en),
    .angle (angles.data.roll_angle),
    .sin_q (sz),
    .cos_q (cz)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      // pairwise products
      p_cycz <= mulq(cy, cz);
      p_sxsy <= mulq(sx, sy);
      p_cxsy <= mulq(cx, sy);
      p_cxsz <= mulq(cx, sz);
      p_sxsz <= mulq(sx, sz);
      p_cysz <= mulq(cy, sz);
      p_cxcz <= mulq(cx, cz);
      p_sxcz <= mulq(sx, cz);
      p_sxcy <= mulq(sx, cy);
      p_cxcy <= mulq(cx, cy);
      p_sy   <= sy;
      p_sz   <= sz;
      p_cz   <= cz;

      // triple products, left to right; rounding is sign symmetric
      q_bcz  <= mulq(p_sxsy, p_cz);
      q_ccz  <= mulq(p_cxsy, p_cz);
      q_bsz  <= mulq(p_sxsy, p_sz);
      q_csz  <= mulq(p_cxsy, p_sz);
      q_cycz <= p_cycz;
      q_cxsz <= p_cxsz;
      q_sxsz <= p_sxsz;
      q_cysz <= p_cysz;
      q_cxcz <= p_cxcz;
      q_sxcz <= p_sxcz;
      q_sxcy <= p_sxcy;
      q_cxcy <= p_cxcy;
      q_sy   <= p_sy;

      // basis entries in q30
      s_lx <= 33'(q_cycz);
      s_ly <= 33'(q_bcz) + 33'(q_cxsz);
      s_lz <= 33'(q_sxsz) - 33'(q_ccz);
      s_ux <= -33'(q_cysz);
      s_uy <= 33'(q_cxcz) - 33'(q_bsz);
      s_uz <= 33'(q_csz) + 33'(q_sxcz);
      s_fx <= 33'(q_sy);
      s_fy <= -33'(q_sxcy);
      s_fz <= 33'(q_cxcy);

      // round and saturate into the output register
      out_r.left_x    <= to_out(s_lx);
      out_r.left_y    <= to_out(s_ly);
      out_r.left_z    <= to_out(s_lz);
      out_r.up_x      <= to_out(s_ux);
      out_r.up_y      <= to_out(s_uy);
      out_r.up_z      <= to_out(s_uz);
      out_r.forward_x <= to_out(s_fx);
      out_r.forward_y <= to_out(s_fy);
      out_r.forward_z <= to_out(s_fz);
    end
  end

endmodule

/* design/eara_sincos.sv */
// ----------------------------------------------------------------------------
// eara_sincos
// pipelined sine and cosine of one angle, q30 results
// ----------------------------------------------------------------------------
module eara_sincos (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [eara_pkg::ANGLE_W-1:0] angle,
  output logic signed [31:0]                sin_q,
  output logic signed [31:0]                cos_q
);
  import eara_pkg::*;

  localparam int M_W = $clog2(TURN);
  localparam int R_W = $clog2(QUARTER);

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  typedef struct packed {
    logic [31:0]        x2;
    quad_t              quad;
    logic [31:0]        ts;
    logic [31:0]        tc;
    logic signed [33:0] ss;
    logic signed [33:0] sc;
    logic [33:0]        av_s;
    logic [33:0]        av_c;
    logic [33:0]        qv_s;
    logic [33:0]        qv_c;
  } ser_t;

  logic signed [31:0] v;
  logic signed [31:0] m_c;
  logic [M_W-1:0]     m_r;
  quad_t              quad_c;
  quad_t              quad_r;
  quad_t              quad_x;
  logic [R_W-1:0]     r_c;
  logic [R_W-1:0]     r_r;
  logic [63:0]        rk;
  logic [30:0]        x_r;
  logic [63:0]        xx;
  ser_t               st [3*SERIES_TERMS+1];
  ser_t               st_next [3*SERIES_TERMS+1];
  logic signed [33:0] s_cl;
  logic signed [33:0] c_cl;

  // wrap into one turn
  always_comb begin
    v = 32'(angle);
    if (v >= TURN) begin
      m_c = v - TURN;
    end else if (v < -TURN) begin
      m_c = v + 2 * TURN;
    end else if (v < 0) begin
      m_c = v + TURN;
    end else begin
      m_c = v;
    end
  end

  always_comb begin
    if (m_r >= M_W'(3 * QUARTER)) begin
      quad_c = QUAD_3;
      r_c    = R_W'(m_r - M_W'(3 * QUARTER));
    end else if (m_r >= M_W'(2 * QUARTER)) begin
      quad_c = QUAD_2;
      r_c    = R_W'(m_r - M_W'(2 * QUARTER));
    end else if (m_r >= M_W'(QUARTER)) begin
      quad_c = QUAD_1;
      r_c    = R_W'(m_r - M_W'(QUARTER));
    end else begin
      quad_c = QUAD_0;
      r_c    = R_W'(m_r);
    end
  end

  assign rk = 64'(r_r) * DEG2RAD_Q40;
  assign xx = 64'(x_r) * 64'(x_r);

  // each series term: multiply, reciprocal estimate, correct and accumulate
  always_comb begin
    logic [33:0] rem_s;
    logic [33:0] rem_c;
    logic [31:0] tn_s;
    logic [31:0] tn_c;
    st_next[0].x2   = 32'((xx + (64'(1) << (QBITS - 1))) >> QBITS);
    st_next[0].quad = quad_x;
    st_next[0].ts   = 32'(x_r);
    st_next[0].tc   = 32'(1) << QBITS;
    st_next[0].ss   = 34'(x_r);
    st_next[0].sc   = 34'(1) << QBITS;
    st_next[0].av_s = '0;
    st_next[0].av_c = '0;
    st_next[0].qv_s = '0;
    st_next[0].qv_c = '0;
    for (int k = 0; k < SERIES_TERMS; k++) begin
      st_next[3*k+1]      = st[3*k];
      st_next[3*k+1].av_s = 34'((64'(st[3*k].ts) * 64'(st[3*k].x2)) >> QBITS);
      st_next[3*k+1].av_c = 34'((64'(st[3*k].tc) * 64'(st[3*k].x2)) >> QBITS);

      st_next[3*k+2]      = st[3*k+1];
      st_next[3*k+2].qv_s = 34'((68'(st[3*k+1].av_s) * 68'(SIN_RECIP[k]))
                                >> RECIP_SHIFT);
      st_next[3*k+2].qv_c = 34'((68'(st[3*k+1].av_c) * 68'(COS_RECIP[k]))
                                >> RECIP_SHIFT);

      rem_s = st[3*k+2].av_s - 34'(st[3*k+2].qv_s * 34'(SIN_DIV[k]));
      rem_c = st[3*k+2].av_c - 34'(st[3*k+2].qv_c * 34'(COS_DIV[k]));
      tn_s  = 32'((rem_s >= 34'(SIN_DIV[k])) ? st[3*k+2].qv_s + 34'(1)
                                             : st[3*k+2].qv_s);
      tn_c  = 32'((rem_c >= 34'(COS_DIV[k])) ? st[3*k+2].qv_c + 34'(1)
                                             : st[3*k+2].qv_c);

      st_next[3*k+3]    = st[3*k+2];
      st_next[3*k+3].ts = tn_s;
      st_next[3*k+3].tc = tn_c;
      st_next[3*k+3].ss = (k % 2 == 0) ? st[3*k+2].ss - 34'(tn_s)
                                       : st[3*k+2].ss + 34'(tn_s);
      st_next[3*k+3].sc = (k % 2 == 0) ? st[3*k+2].sc - 34'(tn_c)
                                       : st[3*k+2].sc + 34'(tn_c);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= M_W'(m_c);
      quad_r <= quad_c;
      r_r    <= r_c;
      quad_x <= quad_r;
      x_r    <= 31'((rk + (64'(1) << (ANGLE_FRACTION_BITS + 9)))
                    >> (ANGLE_FRACTION_BITS + 10));
      st     <= st_next;
    end
  end

  // clamp to [0, 1] then fold back into the quadrant
  always_comb begin
    if (st[3*SERIES_TERMS].ss < 0) begin
      s_cl = '0;
    end else if (st[3*SERIES_TERMS].ss > (34'sd1 <<< QBITS)) begin
      s_cl = 34'sd1 <<< QBITS;
    end else begin
      s_cl = st[3*SERIES_TERMS].ss;
    end
    if (st[3*SERIES_TERMS].sc < 0) begin
      c_cl = '0;
    end else if (st[3*SERIES_TERMS].sc > (34'sd1 <<< QBITS)) begin
      c_cl = 34'sd1 <<< QBITS;
    end else begin
      c_cl = st[3*SERIES_TERMS].sc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (st[3*SERIES_TERMS].quad)
        QUAD_0: begin
          sin_q <= 32'(s_cl);
          cos_q <= 32'(c_cl);
        end
        QUAD_1: begin
          sin_q <= 32'(c_cl);
          cos_q <= -32'(s_cl);
        end
        QUAD_2: begin
          sin_q <= -32'(s_cl);
          cos_q <= -32'(c_cl);
        end
        default: begin
          sin_q <= -32'(c_cl);
          cos_q <= 32'(s_cl);
        end
      endcase
    end
  end

endmodule

/* design/eara_check.sv */
// ----------------------------------------------------------------------------
// eara_check
// port level checks for the rotation axes block, bound to the top level
// ----------------------------------------------------------------------------
`include "euler_angles_to_rotation_axes_assert.svh"

module eara_check (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input eara_pkg::axes_t out_data
);
  import eara_pkg::*;

  // a waiting result keeps its value until the transaction completes
  `EARA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output changed while stalled")

  // an empty output slot never blocks the input side
  `EARA_ASSERT_IMP(a_ready_empty, !out_valid, in_ready, "input blocked with empty output")

  // the input side follows the output side without extra stall
  `EARA_ASSERT_IMP(a_ready_follow, out_ready, in_ready, "input blocked while output drains")

  // forward x is a saturated unit value
  `EARA_ASSERT_IMP(a_fwd_range, out_valid, out_data.forward_x >= -16'sd16384 && out_data.forward_x <= 16'sd16384, "forward_x out of range")

endmodule

bind euler_angles_to_rotation_axes eara_check u_eara_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (angles.valid),
  .in_ready  (angles.ready),
  .out_valid (axes.valid),
  .out_ready (axes.ready),
  .out_data  (axes.data)
);
